// ----- design/hwkn_pkg.sv -----
`default_nettype none
package hwkn_pkg;

  localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [20:0] KANA_FIRST     = 21'h00FF61;
  localparam logic [20:0] KANA_LAST      = 21'h00FF9F;
  localparam logic [20:0] MARK_VOICED    = 21'h00FF9E;
  localparam logic [20:0] MARK_SEMI      = 21'h00FF9F;
  localparam logic [5:0]  KANA_OFFSET    = 6'h21;

  localparam logic [7:0] CONT_MARK  = 8'h80;
  localparam logic [7:0] LEAD2_MARK = 8'hC0;
  localparam logic [7:0] LEAD3_MARK = 8'hE0;
  localparam logic [7:0] LEAD4_MARK = 8'hF0;

  localparam int MaxCp = 3;

  // code points produced by one input byte, in order
  typedef struct packed {
    logic [1:0]                 n;
    logic [MaxCp-1:0][20:0]     cp;
  } cp_list_t;

  // result of finishing one code point
  typedef struct packed {
    logic        emit_a;
    logic [20:0] a;
    logic        emit_b;
    logic [20:0] b;
    logic        kp;
    logic [15:0] pk;
  } done_t;

  // result of looking at a byte in lead position
  typedef struct packed {
    logic        done;
    logic [20:0] cp;
    logic [1:0]  left;
    logic [20:0] pc;
  } lead_t;

  function automatic logic [15:0] kana_map(logic [5:0] idx);
    logic [15:0] r;
    case (idx)
      6'd0:  r = 16'h3002;  6'd1:  r = 16'h300c;  6'd2:  r = 16'h300d;  6'd3:  r = 16'h3001;
      6'd4:  r = 16'h30fb;  6'd5:  r = 16'h30f2;  6'd6:  r = 16'h30a1;  6'd7:  r = 16'h30a3;
      6'd8:  r = 16'h30a5;  6'd9:  r = 16'h30a7;  6'd10: r = 16'h30a9;  6'd11: r = 16'h30e3;
      6'd12: r = 16'h30e5;  6'd13: r = 16'h30e7;  6'd14: r = 16'h30c3;  6'd15: r = 16'h30fc;
      6'd16: r = 16'h30a2;  6'd17: r = 16'h30a4;  6'd18: r = 16'h30a6;  6'd19: r = 16'h30a8;
      6'd20: r = 16'h30aa;  6'd21: r = 16'h30ab;  6'd22: r = 16'h30ad;  6'd23: r = 16'h30af;
      6'd24: r = 16'h30b1;  6'd25: r = 16'h30b3;  6'd26: r = 16'h30b5;  6'd27: r = 16'h30b7;
      6'd28: r = 16'h30b9;  6'd29: r = 16'h30bb;  6'd30: r = 16'h30bd;  6'd31: r = 16'h30bf;
      6'd32: r = 16'h30c1;  6'd33: r = 16'h30c4;  6'd34: r = 16'h30c6;  6'd35: r = 16'h30c8;
      6'd36: r = 16'h30ca;  6'd37: r = 16'h30cb;  6'd38: r = 16'h30cc;  6'd39: r = 16'h30cd;
      6'd40: r = 16'h30ce;  6'd41: r = 16'h30cf;  6'd42: r = 16'h30d2;  6'd43: r = 16'h30d5;
      6'd44: r = 16'h30d8;  6'd45: r = 16'h30db;  6'd46: r = 16'h30de;  6'd47: r = 16'h30df;
      6'd48: r = 16'h30e0;  6'd49: r = 16'h30e1;  6'd50: r = 16'h30e2;  6'd51: r = 16'h30e4;
      6'd52: r = 16'h30e6;  6'd53: r = 16'h30e8;  6'd54: r = 16'h30e9;  6'd55: r = 16'h30ea;
      6'd56: r = 16'h30eb;  6'd57: r = 16'h30ec;  6'd58: r = 16'h30ed;  6'd59: r = 16'h30ef;
      6'd60: r = 16'h30f3;  6'd61: r = 16'h3099;  6'd62: r = 16'h309a;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] combine_mark(logic [15:0] base, logic semi);
    logic [15:0] r;
    r = base;
    if (!semi) begin
      case (base)
        16'h30a6: r = 16'h30f4;
        16'h30ab, 16'h30ad, 16'h30af, 16'h30b1, 16'h30b3,
        16'h30b5, 16'h30b7, 16'h30b9, 16'h30bb, 16'h30bd,
        16'h30bf, 16'h30c1, 16'h30c4, 16'h30c6, 16'h30c8,
        16'h30cf, 16'h30d2, 16'h30d5, 16'h30d8, 16'h30db: r = base + 16'd1;
        default: r = base;
      endcase
    end else begin
      case (base)
        16'h30cf, 16'h30d2, 16'h30d5, 16'h30d8, 16'h30db: r = base + 16'd2;
        default: r = base;
      endcase
    end
    return r;
  endfunction

  function automatic done_t cp_done(logic kp, logic [15:0] pk, logic [20:0] cp);
    done_t r;
    logic  is_mark;
    logic  is_kana;
    r       = '0;
    is_mark = (cp == MARK_VOICED) || (cp == MARK_SEMI);
    is_kana = (cp >= KANA_FIRST) && (cp <= KANA_LAST);
    if (kp && is_mark) begin
      // a mark that cannot combine leaves the kana as it is
      r.emit_a = 1'b1;
      r.a      = {5'b0, combine_mark(pk, cp[0])};
    end else begin
      r.emit_a = kp;
      r.a      = {5'b0, pk};
      if (is_kana) begin
        r.kp = 1'b1;
        r.pk = kana_map(cp[5:0] - KANA_OFFSET);
      end else begin
        r.emit_b = 1'b1;
        r.b      = cp;
      end
    end
    return r;
  endfunction

  function automatic lead_t take_lead(logic [7:0] b);
    lead_t r;
    r = '0;
    if (!b[7]) begin
      r.done = 1'b1;
      r.cp   = {13'b0, b};
    end else if (b[7:5] == 3'b110) begin
      r.left = 2'd1;
      r.pc   = {16'b0, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      r.left = 2'd2;
      r.pc   = {17'b0, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      r.left = 2'd3;
      r.pc   = {18'b0, b[2:0]};
    end else begin
      r.done = 1'b1;
      r.cp   = CP_REPLACEMENT;
    end
    return r;
  endfunction

  function automatic cp_list_t list_push(cp_list_t l, logic en, logic [20:0] cp);
    cp_list_t r;
    r = l;
    if (en && (l.n != 2'd3)) begin
      r.cp[l.n] = cp;
      r.n       = l.n + 2'd1;
    end
    return r;
  endfunction

  function automatic cp_list_t push_done(cp_list_t l, done_t d);
    cp_list_t r;
    r = list_push(l, d.emit_a, d.a);
    r = list_push(r, d.emit_b, d.b);
    return r;
  endfunction

  // encoded length minus one
  function automatic logic [1:0] enc_len_m1(logic [20:0] cp);
    logic [1:0] r;
    if (cp <= 21'h00007F) begin
      r = 2'd0;
    end else if (cp <= 21'h0007FF) begin
      r = 2'd1;
    end else if (cp <= 21'h00FFFF) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic [7:0] enc_byte(logic [20:0] cp, logic [1:0] k);
    logic [7:0] r;
    case (enc_len_m1(cp))
      2'd0: r = cp[7:0];
      2'd1: begin
        case (k)
          2'd0:    r = LEAD2_MARK | {3'b0, cp[10:6]};
          default: r = CONT_MARK | {2'b0, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (k)
          2'd0:    r = LEAD3_MARK | {4'b0, cp[15:12]};
          2'd1:    r = CONT_MARK | {2'b0, cp[11:6]};
          default: r = CONT_MARK | {2'b0, cp[5:0]};
        endcase
      end
      default: begin
        case (k)
          2'd0:    r = LEAD4_MARK | {5'b0, cp[20:18]};
          2'd1:    r = CONT_MARK | {2'b0, cp[17:12]};
          2'd2:    r = CONT_MARK | {2'b0, cp[11:6]};
          default: r = CONT_MARK | {2'b0, cp[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/utf8_halfwidth_kana_normalizer.sv -----
// UTF-8 halfwidth katakana normalizer.
// Input channel: in_byte / text_last with in_valid and in_stall. One byte of
// UTF-8 text per transfer; text_last marks the final byte of a text.
// Output channel: out_byte / run_last / text_end with out_valid and out_stall.
// run_last marks the last byte caused by one input byte, text_end the last
// byte of the whole normalized text. An input byte that finishes nothing
// (a lead byte, a held kana) gives no output transfer.
// Each input byte is decoded into up to three code points, which go into a
// job register; a serializer then gives one encoded byte per cycle, while
// the output is not stalled, into the output register. The first output byte
// passes through the job register and then the output register.
// Throughput is one output byte per cycle while out_stall is low: the input
// is held while a job is serialized and the next byte is taken as the job's
// last byte goes into the output register.
// When out_stall is high the output register holds, the serializer waits and
// in_stall rises once the job register is full. Reset clears the decoder, any
// held kana, the job and out_valid.
`default_nettype none
module utf8_halfwidth_kana_normalizer (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] in_byte,
  input  wire logic       text_last,
  input  wire logic       in_valid,
  output logic            in_stall,
  output logic [7:0]      out_byte,
  output logic            run_last,
  output logic            text_end,
  output logic            out_valid,
  input  wire logic       out_stall
);

  // decoder state
  logic [20:0] partial_cp;
  logic [1:0]  bytes_left;
  logic        kana_pending;
  logic [15:0] pending_kana;

  logic [20:0] partial_cp_next;
  logic [1:0]  bytes_left_next;
  logic        kana_pending_next;
  logic [15:0] pending_kana_next;

  hwkn_pkg::cp_list_t lst;
  hwkn_pkg::done_t    d;
  hwkn_pkg::lead_t    ld;
  logic               do_lead;

  // job and serializer
  logic [hwkn_pkg::MaxCp-1:0][20:0] job_cp;
  logic [1:0]  job_n;
  logic        job_last;
  logic        job_busy;
  logic [1:0]  cp_idx;
  logic [1:0]  byte_idx;

  logic [20:0] cur_cp;
  logic [1:0]  cur_len_m1;
  logic        cp_end;
  logic        job_end;
  logic        out_adv;
  logic        ser_step;
  logic        in_xfer;

  always_comb begin
    lst               = '0;
    d                 = '0;
    ld                = hwkn_pkg::take_lead(in_byte);
    do_lead           = 1'b0;
    partial_cp_next   = partial_cp;
    bytes_left_next   = bytes_left;
    kana_pending_next = kana_pending;
    pending_kana_next = pending_kana;

    if (bytes_left != 2'd0) begin
      if (in_byte[7:6] == 2'b10) begin
        partial_cp_next = {partial_cp[14:0], in_byte[5:0]};
        bytes_left_next = bytes_left - 2'd1;
        if (bytes_left_next == 2'd0) begin
          d                 = hwkn_pkg::cp_done(kana_pending, pending_kana, partial_cp_next);
          lst               = hwkn_pkg::push_done(lst, d);
          kana_pending_next = d.kp;
          pending_kana_next = d.pk;
          partial_cp_next   = '0;
        end
      end else begin
        // broken sequence, then the same byte is taken as a new lead
        bytes_left_next   = 2'd0;
        partial_cp_next   = '0;
        d                 = hwkn_pkg::cp_done(kana_pending, pending_kana,
                                              hwkn_pkg::CP_REPLACEMENT);
        lst               = hwkn_pkg::push_done(lst, d);
        kana_pending_next = d.kp;
        pending_kana_next = d.pk;
        do_lead           = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    if (do_lead) begin
      if (ld.done) begin
        d                 = hwkn_pkg::cp_done(kana_pending_next, pending_kana_next, ld.cp);
        lst               = hwkn_pkg::push_done(lst, d);
        kana_pending_next = d.kp;
        pending_kana_next = d.pk;
      end else begin
        bytes_left_next = ld.left;
        partial_cp_next = ld.pc;
      end
    end

    if (text_last) begin
      // truncated sequence at end of text
      if (bytes_left_next != 2'd0) begin
        d                 = hwkn_pkg::cp_done(kana_pending_next, pending_kana_next,
                                              hwkn_pkg::CP_REPLACEMENT);
        lst               = hwkn_pkg::push_done(lst, d);
        kana_pending_next = d.kp;
        pending_kana_next = d.pk;
      end
      lst = hwkn_pkg::list_push(lst, kana_pending_next, {5'b0, pending_kana_next});
      kana_pending_next = 1'b0;
      pending_kana_next = '0;
      partial_cp_next   = '0;
      bytes_left_next   = 2'd0;
    end
  end

  assign cur_cp     = job_cp[cp_idx];
  assign cur_len_m1 = hwkn_pkg::enc_len_m1(cur_cp);
  assign cp_end     = (byte_idx == cur_len_m1);
  assign job_end    = cp_end && (cp_idx == job_n - 2'd1);
  assign out_adv    = !out_valid || !out_stall;
  assign ser_step   = job_busy && out_adv;
  assign in_stall   = job_busy && !(ser_step && job_end);
  assign in_xfer    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_cp   <= '0;
      bytes_left   <= 2'd0;
      kana_pending <= 1'b0;
      pending_kana <= '0;
      job_busy     <= 1'b0;
      cp_idx       <= 2'd0;
      byte_idx     <= 2'd0;
      out_valid    <= 1'b0;
    end else begin
      if (in_xfer) begin
        partial_cp   <= partial_cp_next;
        bytes_left   <= bytes_left_next;
        kana_pending <= kana_pending_next;
        pending_kana <= pending_kana_next;
      end

      if (out_adv) begin
        out_valid <= job_busy;
      end

      if (ser_step) begin
        out_byte <= hwkn_pkg::enc_byte(cur_cp, byte_idx);
        run_last <= job_end;
        text_end <= job_end && job_last;
      end

      // a new job takes over the slot freed by the last byte of the old one
      if (in_xfer && (lst.n != 2'd0)) begin
        job_busy <= 1'b1;
        job_cp   <= lst.cp;
        job_n    <= lst.n;
        job_last <= text_last;
        cp_idx   <= 2'd0;
        byte_idx <= 2'd0;
      end else if (ser_step) begin
        if (job_end) begin
          job_busy <= 1'b0;
          cp_idx   <= 2'd0;
          byte_idx <= 2'd0;
        end else if (cp_end) begin
          byte_idx <= 2'd0;
          cp_idx   <= cp_idx + 2'd1;
        end else begin
          byte_idx <= byte_idx + 2'd1;
        end
      end
    end
  end

endmodule
`default_nettype wire
